// File: rtl/i2cmb_pkg.sv
// Shared types, command codes and helper functions for the I2C master bit engine.
// Used by i2cmb_core and i2c_master_bit_engine; no other dependencies.
`default_nettype none

package i2cmb_pkg;

  // Command codes carried by an input item.
  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_START = 4'd1,
    CMD_STOP  = 4'd2,
    CMD_WRITE = 4'd3,
    CMD_WAIT  = 4'd4,
    CMD_READ  = 4'd5,
    CMD_ACK   = 4'd6,
    CMD_NACK  = 4'd7,
    CMD_PROBE = 4'd8
  } cmd_e;

  localparam int unsigned HalfPeriodWidth = 16;
  localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd100;
  localparam int unsigned PhaseWidth = 5;

  // Fields of one input item.
  typedef struct packed {
    logic       scl_in;
    logic       sda_in;
    logic [7:0] write_data;
    logic [3:0] command;
  } in_item_t;

  // Fields of one result item.
  typedef struct packed {
    logic       ack_status;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } res_item_t;

  // Sub-command and local phase, used to walk a probe as its pieces.
  typedef struct packed {
    cmd_e                  cmd;
    logic [PhaseWidth-1:0] phase;
  } step_t;

  // Number of bus phases in a command sequence.
  function automatic logic [PhaseWidth-1:0] phase_total(cmd_e c);
    logic [PhaseWidth-1:0] n;
    unique case (c)
      CMD_WRITE, CMD_READ: n = 5'd16;
      CMD_ACK:             n = 5'd4;
      CMD_PROBE:           n = 5'd25;
      default:             n = 5'd3;
    endcase
    return n;
  endfunction

  // A probe is start, address write, wait for ack and stop in a row.
  function automatic step_t split_phase(cmd_e c, logic [PhaseWidth-1:0] p);
    step_t s;
    s.cmd   = c;
    s.phase = p;
    if (c == CMD_PROBE) begin
      if (p < 5'd3) begin
        s.cmd   = CMD_START;
      end else if (p < 5'd19) begin
        s.cmd   = CMD_WRITE;
        s.phase = p - 5'd3;
      end else if (p < 5'd22) begin
        s.cmd   = CMD_WAIT;
        s.phase = p - 5'd19;
      end else begin
        s.cmd   = CMD_STOP;
        s.phase = p - 5'd22;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: stream handshake, result register, config register.
// Depends on i2cmb_pkg and i2cmb_core.
`default_nettype none

// One input item is one tick of bus timing and gives exactly one result item.
// Items are taken every cycle while the result register is empty or being read,
// so the sustained rate is one item per clock; the result of an item appears on
// the master side in the cycle after it is accepted. Every bus phase lasts
// half_period_ticks items (zero counts as one). A command in an item is started
// only while the engine is idle. Write half_period_ticks only while idle.
module i2c_master_bit_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] command, [11:4] write_data, [12] sda_in, [13] scl_in, [15:14] zero
  input  wire logic [15:0] s_axis_tdata,
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] read_data, [12] ack_status, [15:13] zero
  output logic [15:0]      m_axis_tdata,
  // Configuration: half_period_ticks.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [i2cmb_pkg::HalfPeriodWidth-1:0] cfg_data_i
);
  import i2cmb_pkg::*;

  logic [HalfPeriodWidth-1:0] half_period_q;
  in_item_t                   item;
  res_item_t                  res;
  res_item_t                  out_q;
  logic                       out_valid_q;
  logic                       accept;
  logic                       core_busy;
  logic                       phase_ok;

  // Configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
    end else if (cfg_valid_i) begin
      half_period_q <= cfg_data_i;
    end
  end

  // Take an item whenever the result register is free or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign item          = s_axis_tdata[$bits(in_item_t)-1:0];

  i2cmb_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .item_i       (item),
    .half_period_i(half_period_q),
    .res_o        (res),
    .busy_o       (core_busy),
    .phase_ok_o   (phase_ok)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16-$bits(res_item_t)){1'b0}}, out_q};

  // The sequencer state stays consistent at all times.
  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_ok)
    else $error("sequencer phase or tick counter out of range");

  // A finished command never reports busy in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && res.done_res |-> !res.busy_res)
    else $error("done and busy reported together");

  // The engine state only moves on an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !accept |=> core_busy == $past(core_busy))
    else $error("engine state changed without an accepted item");

  // A result is produced in the cycle after each accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> m_axis_tvalid)
    else $error("accepted item did not produce a result");

endmodule

`default_nettype wire

// File: rtl/i2cmb_core.sv
// Bus phase sequencer of the I2C master bit engine: state registers and next-state logic.
// Depends on i2cmb_pkg.
`default_nettype none

module i2cmb_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire i2cmb_pkg::in_item_t                  item_i,
  input  wire logic [i2cmb_pkg::HalfPeriodWidth-1:0] half_period_i,
  output i2cmb_pkg::res_item_t                      res_o,
  output logic                                      busy_o,
  output logic                                      phase_ok_o
);
  import i2cmb_pkg::*;

  logic [PhaseWidth-1:0]      phase_q, phase_d;
  logic [HalfPeriodWidth-1:0] tick_q, tick_d;
  cmd_e                       active_q, active_d;
  logic [7:0]                 shift_q, shift_d;
  logic [7:0]                 rbyte_q, rbyte_d;
  logic                       scl_q, scl_d;
  logic                       sda_q, sda_d;
  logic                       ack_q, ack_d;
  logic                       busy_q, busy_d;
  logic                       done;

  logic [HalfPeriodWidth-1:0] hp;
  logic [HalfPeriodWidth:0]   cnt;
  logic                       phase_end;
  logic                       last_phase;
  step_t                      lv;
  step_t                      en;
  logic                       en_valid;
  logic [PhaseWidth-1:0]      en_phase;
  cmd_e                       en_cmd;
  cmd_e                       new_cmd;

  // A zero half period counts as one tick.
  assign hp         = (half_period_i == '0) ? {{(HalfPeriodWidth-1){1'b0}}, 1'b1}
                                            : half_period_i;
  assign cnt        = {1'b0, tick_q} + {{HalfPeriodWidth{1'b0}}, 1'b1};
  assign phase_end  = (cnt >= {1'b0, hp});
  assign last_phase = ({1'b0, phase_q} + 6'd1) >= {1'b0, phase_total(active_q)};
  assign lv         = split_phase(active_q, phase_q);
  assign new_cmd    = cmd_e'(item_i.command);

  // Next state: end the phase, set the next one's levels, or start a command if idle.
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    active_d = active_q;
    shift_d  = shift_q;
    rbyte_d  = rbyte_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    busy_d   = busy_q;
    done     = 1'b0;
    en_valid = 1'b0;
    en_cmd   = active_q;
    en_phase = '0;

    if (busy_q) begin
      if (phase_end) begin
        // Leave the current phase.
        if (lv.cmd == CMD_WRITE && lv.phase[0]) begin
          scl_d   = 1'b0;
          shift_d = {shift_q[6:0], 1'b0};
          if (lv.phase == 5'd15) begin
            sda_d = 1'b1;
          end
        end else if (lv.cmd == CMD_WAIT && lv.phase == 5'd1) begin
          ack_d = item_i.sda_in;
        end else if (lv.cmd == CMD_READ) begin
          if (!lv.phase[0]) begin
            shift_d = {shift_q[6:0], item_i.sda_in};
          end else if (lv.phase == 5'd15) begin
            rbyte_d = shift_q;
          end
        end
        tick_d = '0;
        if (last_phase) begin
          busy_d   = 1'b0;
          active_d = CMD_NONE;
          phase_d  = '0;
          done     = 1'b1;
        end else begin
          phase_d  = phase_q + 5'd1;
          en_valid = 1'b1;
          en_cmd   = active_q;
          en_phase = phase_q + 5'd1;
        end
      end else begin
        tick_d = cnt[HalfPeriodWidth-1:0];
      end
    end else if (item_i.command >= CMD_START && item_i.command <= CMD_PROBE) begin
      if (new_cmd == CMD_PROBE && !(item_i.sda_in && item_i.scl_in)) begin
        // Bus not idle: the probe reports no device at once.
        ack_d = 1'b1;
        done  = 1'b1;
      end else begin
        active_d = new_cmd;
        busy_d   = 1'b1;
        phase_d  = '0;
        tick_d   = '0;
        shift_d  = (new_cmd == CMD_READ) ? 8'h00 : item_i.write_data;
        en_valid = 1'b1;
        en_cmd   = new_cmd;
        en_phase = '0;
      end
    end

    // Enter the next phase: drive levels are set at its start.
    en = split_phase(en_cmd, en_phase);
    if (en_valid) begin
      unique case (en.cmd)
        CMD_START: begin
          if (en.phase == 5'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (en.phase == 5'd1) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        CMD_STOP: begin
          if (en.phase == 5'd0) begin
            sda_d = 1'b0;
          end else if (en.phase == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (!en.phase[0]) begin
            sda_d = shift_d[7];
          end else begin
            scl_d = 1'b1;
          end
        end
        CMD_WAIT, CMD_NACK: begin
          if (en.phase == 5'd0) begin
            sda_d = 1'b1;
          end else if (en.phase == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        CMD_READ: begin
          scl_d = !en.phase[0];
        end
        CMD_ACK: begin
          if (en.phase == 5'd0) begin
            sda_d = 1'b0;
          end else if (en.phase == 5'd1) begin
            scl_d = 1'b1;
          end else if (en.phase == 5'd2) begin
            scl_d = 1'b0;
          end else begin
            sda_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      tick_q   <= '0;
      active_q <= CMD_NONE;
      shift_q  <= '0;
      rbyte_q  <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_q    <= 1'b1;
      busy_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      active_q <= active_d;
      shift_q  <= shift_d;
      rbyte_q  <= rbyte_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_q    <= ack_d;
      busy_q   <= busy_d;
    end
  end

  // Result of this item is the state it leaves behind.
  assign res_o.scl_release = scl_d;
  assign res_o.sda_release = sda_d;
  assign res_o.busy_res    = busy_d;
  assign res_o.done_res    = done;
  assign res_o.read_data   = rbyte_d;
  assign res_o.ack_status  = ack_d;

  // Status for checks at the top level.
  assign busy_o     = busy_q;
  assign phase_ok_o = busy_q ? (active_q != CMD_NONE && tick_q < hp
                                && phase_q < phase_total(active_q))
                             : (phase_q == '0 && active_q == CMD_NONE);

endmodule

`default_nettype wire
